### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bdq_pkg.sv
package bdq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WIDTH_DEF = 32;

	localparam int OP_W   = 3;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 6;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_REVERSE    = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

### src/bounded_deque_with_reverse_unit.sv
// Bounded deque with push/pop at both ends, indexed read and in-place reverse.
// Command channel: op, value and index are taken at a rising edge with start
// high and busy low. Every command yields one response: done is high for one
// cycle with status, read_data and count valid in that same cycle.
// Storage is a circular buffer of DEPTH words with a head pointer and a
// direction bit, so every command, reverse included, is one memory access.
// A single add/wrap unit maps logical positions to physical addresses.
// The accepted command is held in the command registers for the execute
// state, whose closing edge registers done, status, read data and count.
// A command is taken only while busy is low; busy is high only in the execute
// cycle, so a new command may be taken in the cycle that done is shown.
// The receiver cannot stall: each response is presented once and is gone.
// Reset clears count, head, direction and the sequencer; memory contents are
// not cleared, and only written entries are ever read back.
`include "assert_macros.svh"

module bounded_deque_with_reverse_unit
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [DATA_W-1:0] value,
	input  logic [IDX_W-1:0]  index,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [DATA_W-1:0] read_data,
	output logic [CNT_W-1:0]  count
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t             state_q;
	logic [OP_W-1:0]    op_q;
	logic [WIDTH-1:0]   value_q;
	logic [IDX_W-1:0]   index_q;
	logic [AW-1:0]      head_q;
	logic               dir_q;
	logic [CW-1:0]      count_q;
	logic               done_q;
	logic [STAT_W-1:0]  status_q;
	logic               rd_ok_q;
	logic [WIDTH-1:0]   rdata_s1;
	logic [WIDTH-1:0]   mem [DEPTH];

	logic               full;
	logic               empty;
	logic               in_range;
	logic [AW-1:0]      off;
	logic               neg;
	logic [AW:0]        opb;
	logic [AW:0]        raw;
	logic [AW:0]        wrapped;
	logic [AW-1:0]      addr;
	logic               we;

	assign busy      = (state_q == S_EXEC);
	assign done      = done_q;
	assign status    = status_q;
	assign count     = CNT_W'(count_q);
	assign read_data = rd_ok_q ? DATA_W'(rdata_s1) : '0;

	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);
	assign in_range = CMPW'(index_q) < CMPW'(count_q);

	always_comb begin
		off = '0;
		neg = dir_q;
		case (op_q)
			OP_PUSH_BACK: begin
				off = AW'(count_q);
			end
			OP_PUSH_FRONT: begin
				off = AW'(1);
				neg = ~dir_q;
			end
			OP_POP_FRONT: begin
				off = AW'(1);
			end
			OP_READ: begin
				off = AW'(index_q);
			end
			OP_REVERSE: begin
				off = AW'(count_q - 1'b1);
			end
			default: begin
				off = '0;
			end
		endcase
	end

	// shared position unit: head +/- offset, modulo DEPTH
	always_comb begin
		opb = neg ? (~{1'b0, off} + 1'b1) : {1'b0, off};
		raw = {1'b0, head_q} + opb;
		if (neg) begin
			wrapped = raw[AW] ? (raw + DEPTH_A) : raw;
		end else begin
			wrapped = (raw >= DEPTH_A) ? (raw - DEPTH_A) : raw;
		end
		addr = wrapped[AW-1:0];
	end

	assign we = (state_q == S_EXEC) && !full &&
		((op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= value_q;
		end
		if (state_q == S_EXEC) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			dir_q    <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			rd_ok_q  <= 1'b0;
			op_q     <= '0;
			value_q  <= '0;
			index_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						value_q <= WIDTH'(value);
						index_q <= index;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					rd_ok_q  <= 1'b0;
					state_q  <= S_IDLE;
					case (op_q)
						OP_PUSH_BACK: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						OP_PUSH_FRONT: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								head_q  <= addr;
								count_q <= count_q + 1'b1;
							end
						end
						OP_POP_BACK: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								count_q <= count_q - 1'b1;
							end
						end
						OP_POP_FRONT: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								head_q  <= addr;
								count_q <= count_q - 1'b1;
							end
						end
						OP_READ: begin
							if (in_range) begin
								rd_ok_q <= 1'b1;
							end else begin
								status_q <= ST_RANGE;
							end
						end
						OP_REVERSE: begin
							if (!empty) begin
								head_q <= addr;
								dir_q  <= ~dir_q;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLKD(a_accept_exec, clk, arst_n, (start && !busy) |=> busy, "accepted command did not execute")
	`ASSERT_CLKD(a_exec_done, clk, arst_n, busy |=> (done && !busy), "execute cycle without response")
	`ASSERT_CLKD(a_fail_nochg, clk, arst_n, (done && (status != ST_OK)) |-> $stable(count_q), "failed command changed count")
	`ASSERT_ALWAYS(a_count_max, clk, (!arst_n || (count_q <= DEPTH_C)), "count above depth")

endmodule
